/* rtl/tia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_pkg: shared types and codes of the tagged integer alu
// opcodes, error codes, sequencer states and the engine control struct
// ----------------------------------------------------------------------------
package tia_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_NEG = 4'd2, OP_MUL = 4'd3,
    OP_QUOT = 4'd4, OP_REM = 4'd5, OP_EXDIV = 4'd6, OP_POW = 4'd7,
    OP_ABS = 4'd8, OP_SIGN = 4'd9, OP_EQ = 4'd10, OP_NE = 4'd11,
    OP_LT = 4'd12, OP_LE = 4'd13, OP_GT = 4'd14, OP_GE = 4'd15
  } opcode_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_DIV_ZERO = 2'd1, ERR_NEG_EXP = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_MUL, ST_POW, ST_DONE
  } state_t;

  // sequencer to engine control
  typedef struct packed {
    logic load;   // capture operands and set up the iteration
    logic step;   // advance the shared unit by one bit
  } eng_ctrl_t;

endpackage

/* rtl/tia_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tia_engine: shared iterative datapath
// one add/subtract unit does restoring division, shift-add multiply and
// square-and-multiply power, one bit per step
// ----------------------------------------------------------------------------
module tia_engine import tia_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk,
  input  eng_ctrl_t    ctrl,
  input  opcode_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem,
  output logic [W-1:0] prod,
  output logic         pow_mul_done,
  output logic         pow_sq_phase
);
  logic [W-1:0] x_r, x_nxt;    // div: dividend shift; mul: multiplier
  logic [W-1:0] y_r, y_nxt;    // div: divisor; mul: multiplicand
  logic [W-1:0] acc_r, acc_nxt; // div: partial remainder; mul: product
  logic [W-1:0] base_r, base_nxt, expo_r, expo_nxt, pacc_r, pacc_nxt;
  logic         sq_r, sq_nxt;  // pow: 0 multiply acc, 1 square base
  logic [W:0]   diff;
  logic [W-1:0] rsh;

  // magnitudes for division
  logic [W-1:0] ma, mb;
  assign ma = a[W-1] ? (~a + 1'b1) : a;
  assign mb = b[W-1] ? (~b + 1'b1) : b;

  // shared unit: restoring subtract of the shifted remainder
  assign rsh  = {acc_r[W-2:0], x_r[W-1]};
  assign diff = {1'b0, rsh} - {1'b0, y_r};

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; acc_nxt = acc_r;
    base_nxt = base_r; expo_nxt = expo_r; pacc_nxt = pacc_r; sq_nxt = sq_r;
    if (ctrl.load) begin
      acc_nxt = '0;
      if (op == OP_MUL) begin
        x_nxt = b; y_nxt = a;
      end else if (op == OP_POW) begin
        base_nxt = a; expo_nxt = b; pacc_nxt = {{(W-1){1'b0}}, 1'b1};
        sq_nxt = 1'b0;
        x_nxt = b[0] ? a : '0; y_nxt = {{(W-1){1'b0}}, 1'b1};
      end else begin
        x_nxt = ma; y_nxt = mb;
      end
    end else if (ctrl.step) begin
      if (op == OP_MUL || op == OP_POW) begin
        // shift-add step: acc += y when x lsb set
        if (x_r[0]) acc_nxt = acc_r + y_r;
        x_nxt = {1'b0, x_r[W-1:1]};
        y_nxt = {y_r[W-2:0], 1'b0};
      end else begin
        acc_nxt = diff[W] ? rsh : diff[W-1:0];
        x_nxt = {x_r[W-2:0], ~diff[W]};
      end
    end
    // pow: a multiply finishes, fold it in and set up the next one
    if (!ctrl.load && op == OP_POW && pow_mul_done) begin
      if (!sq_r) begin
        if (expo_r[0]) pacc_nxt = acc_r;
        sq_nxt = 1'b1;
        x_nxt = base_r; y_nxt = base_r; acc_nxt = '0;
      end else begin
        base_nxt = acc_r;
        expo_nxt = {1'b0, expo_r[W-1:1]};
        sq_nxt = 1'b0;
        x_nxt = expo_r[1] ? pacc_r : '0; y_nxt = acc_r; acc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; acc_r <= acc_nxt;
    base_r <= base_nxt; expo_r <= expo_nxt; pacc_r <= pacc_nxt; sq_r <= sq_nxt;
  end

  assign quot = x_r;
  assign rem  = acc_r;
  assign prod = (op == OP_POW) ? pacc_r : acc_r;
  // multiply is done once no multiplier bits remain
  assign pow_mul_done = (x_r == '0);
  assign pow_sq_phase = sq_r;
endmodule

/* rtl/tagged_integer_alu_unit.sv */
`timescale 1ns / 1ps
// add, sub, neg, abs, sign, compares: operand capture, dispatch, then result register
// divide family: one restoring step of the shared unit per quotient bit
// multiply: shift-add steps until no multiplier bits remain; pow: per exponent bit two
// shift-add multiplies on the shared adder
// one item at a time, next transfer taken in idle, entered as the result registers
// synchronous active-low reset clears the sequencer and out_valid
// ----------------------------------------------------------------------------
// tagged_integer_alu_unit: integer alu with iterative divide and power
// sequencer around one shared add/subtract engine, result register at out
// ----------------------------------------------------------------------------
module tagged_integer_alu_unit import tia_pkg::*; #(
  parameter int DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic signed [63:0] in_operand_a,
  input  logic signed [63:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [63:0] out_value,
  output logic [1:0]  out_error_code,
  output logic        out_inexact
);
  localparam int W = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  state_t state_r, state_nxt;
  opcode_t op_r;
  logic [W-1:0] a_r, b_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  eng_ctrl_t ctrl;
  logic [W-1:0] quot, rem, prod;
  logic mul_done, sq_phase;
  logic [W-1:0] res;
  logic [1:0] err;
  logic inex, take, fin;
  logic out_valid_r;
  logic [63:0] value_r;
  logic [1:0] err_r;
  logic inex_r;

  assign take = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // operand capture
  always_ff @(posedge clk) begin
    if (take) begin
      op_r <= opcode_t'(in_opcode);
      a_r  <= in_operand_a[W-1:0];
      b_r  <= in_operand_b[W-1:0];
    end
  end

  tia_engine #(.W(W)) u_eng (
    .clk(clk), .ctrl(ctrl), .op(op_r), .a(a_r), .b(b_r),
    .quot(quot), .rem(rem), .prod(prod),
    .pow_mul_done(mul_done), .pow_sq_phase(sq_phase)
  );

  logic is_div, b_zero, expo_zero;
  logic [W-1:0] ex_r;
  assign is_div = (op_r == OP_QUOT) || (op_r == OP_REM) || (op_r == OP_EXDIV);
  assign b_zero = (b_r == '0);
  // track exponent exhaustion: pow ends with the multiply of the top exponent bit
  always_ff @(posedge clk) begin
    if (ctrl.load) ex_r <= b_r;
    else if (state_r == ST_POW && mul_done && sq_phase) ex_r <= {1'b0, ex_r[W-1:1]};
  end
  assign expo_zero = (ex_r[W-1:1] == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV: begin
        // first cycle after capture dispatches
        cnt_nxt = '0;
        if (is_div && !b_zero) state_nxt = ST_MUL;
        else if (op_r == OP_MUL) state_nxt = ST_MUL;
        else if (op_r == OP_POW && !b_r[W-1]) state_nxt = ST_POW;
        else state_nxt = ST_DONE;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (is_div ? (cnt_r == CW'(W - 1)) : mul_done) state_nxt = ST_DONE;
      end
      ST_POW: begin
        // finish when the multiply of the last exponent bit is done
        if (mul_done && !sq_phase && expo_zero) state_nxt = ST_DONE;
      end
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl.load = (state_r == ST_DIV);
    ctrl.step = (state_r == ST_MUL) ||
                (state_r == ST_POW && !mul_done);
  end
  assign fin = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // result select
  logic [W-1:0] nq, nr;
  logic lt_ab, lt_ba;
  assign nq = (a_r[W-1] != b_r[W-1]) ? (~quot + 1'b1) : quot;
  assign nr = a_r[W-1] ? (~rem + 1'b1) : rem;
  assign lt_ab = $signed(a_r) < $signed(b_r);
  assign lt_ba = $signed(b_r) < $signed(a_r);
  always_comb begin
    res = '0; err = ERR_OK; inex = 1'b0;
    case (op_r)
      OP_ADD: res = a_r + b_r;
      OP_SUB: res = a_r - b_r;
      OP_NEG: res = '0 - a_r;
      OP_MUL: res = prod;
      OP_QUOT, OP_REM, OP_EXDIV: begin
        if (b_zero) err = ERR_DIV_ZERO;
        else begin
          res = (op_r == OP_REM) ? nr : nq;
          inex = (op_r == OP_EXDIV) && (rem != '0);
        end
      end
      OP_POW: begin
        if (b_r[W-1]) err = ERR_NEG_EXP;
        else res = prod;
      end
      OP_ABS: res = a_r[W-1] ? ('0 - a_r) : a_r;
      OP_SIGN: res = a_r[W-1] ? '1 : {{(W-1){1'b0}}, (a_r != '0)};
      OP_EQ: res = {{(W-1){1'b0}}, (a_r == b_r)};
      OP_NE: res = {{(W-1){1'b0}}, (a_r != b_r)};
      OP_LT: res = {{(W-1){1'b0}}, lt_ab};
      OP_LE: res = {{(W-1){1'b0}}, !lt_ba};
      OP_GT: res = {{(W-1){1'b0}}, lt_ba};
      default: res = {{(W-1){1'b0}}, !lt_ab};
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (fin) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
    if (fin) begin
      value_r <= 64'($signed(res));
      err_r <= err;
      inex_r <= inex;
    end
  end
  assign out_valid = out_valid_r;
  assign out_value = value_r;
  assign out_error_code = err_r;
  assign out_inexact = inex_r;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> !in_ready) else $error("accepted while busy");
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_error_code != 2'd3) else $error("bad error code");
  a_inex_div: assert property (@(posedge clk) disable iff (!rst_n)
    fin && inex |-> op_r == OP_EXDIV) else $error("inexact on non-divide");
`endif
endmodule

/* tb/tagged_integer_alu_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_integer_alu_unit_tb: self-checking bench of the tagged integer alu
// directed corner items then random items per operation class; a behavioral
// alu model predicts every transfer and a receiver compares each result
// ----------------------------------------------------------------------------
module tagged_integer_alu_unit_tb import tia_pkg::*; ();

  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS = 64'h7fff_ffff_ffff_ffff;

  typedef struct {
    logic [63:0] value;
    err_t        error_code;
    logic        inexact;
  } alu_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  in_opcode;
  logic signed [63:0] in_operand_a;
  logic signed [63:0] in_operand_b;
  logic        out_valid;
  logic        out_ready;
  logic signed [63:0] out_value;
  logic [1:0]  out_error_code;
  logic        out_inexact;

  alu_result_t pending_results[$];
  int          fail_count;

  tagged_integer_alu_unit #(.DATA_WIDTH(64)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_ready(out_ready), .out_value(out_value),
    .out_error_code(out_error_code), .out_inexact(out_inexact)
  );

  // clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // square-and-multiply power, wraps at 64 bits
  function automatic logic [63:0] int_power(logic [63:0] base, logic [63:0] expo);
    logic [63:0] acc;
    acc = 64'd1;
    while (expo != 0) begin
      if (expo[0]) acc = acc * base;
      base = base * base;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // expected result of one alu operation
  function automatic alu_result_t alu_predict(opcode_t op, logic [63:0] a, logic [63:0] b);
    alu_result_t res;
    logic [63:0] ma, mb, q, m;
    logic signed [63:0] sa, sb;
    res.value = 64'd0;
    res.error_code = ERR_OK;
    res.inexact = 1'b0;
    sa = a;
    sb = b;
    case (op)
      OP_ADD: res.value = a + b;
      OP_SUB: res.value = a - b;
      OP_NEG: res.value = 64'd0 - a;
      OP_MUL: res.value = a * b;
      OP_QUOT, OP_REM, OP_EXDIV: begin
        if (b == 0) begin
          res.error_code = ERR_DIV_ZERO;
        end else begin
          ma = a[63] ? 64'd0 - a : a;
          mb = b[63] ? 64'd0 - b : b;
          q = ma / mb;
          m = ma % mb;
          if (a[63] != b[63]) q = 64'd0 - q;
          if (a[63]) m = 64'd0 - m;
          if (op == OP_REM) begin
            res.value = m;
          end else begin
            res.value = q;
            if (op == OP_EXDIV && m != 0) res.inexact = 1'b1;
          end
        end
      end
      OP_POW: begin
        if (b[63]) res.error_code = ERR_NEG_EXP;
        else res.value = int_power(a, b);
      end
      OP_ABS:  res.value = a[63] ? 64'd0 - a : a;
      OP_SIGN: res.value = a[63] ? '1 : {63'd0, a != 0};
      OP_EQ:   res.value = {63'd0, a == b};
      OP_NE:   res.value = {63'd0, a != b};
      OP_LT:   res.value = {63'd0, sa < sb};
      OP_LE:   res.value = {63'd0, sa <= sb};
      OP_GT:   res.value = {63'd0, sa > sb};
      default: res.value = {63'd0, sa >= sb};
    endcase
    return res;
  endfunction

  // mix of extremes, small values and full-width random
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {$urandom, $urandom};
      2: return 64'(signed'($urandom_range(0, 40)) - 20);
      3: case ($urandom_range(0, 3))
           0: return MIN_NEG;
           1: return MAX_POS;
           2: return 64'd0;
           default: return '1;
         endcase
      4: return 64'(signed'($urandom));
      default: return {{32{1'b0}}, $urandom} >> $urandom_range(0, 31);
    endcase
  endfunction

  // send one item after a random gap, record its prediction at transfer
  task automatic send_item(opcode_t op, logic [63:0] a, logic [63:0] b);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  task automatic test_directed();
    send_item(OP_ADD, MAX_POS, 64'd1);
    send_item(OP_SUB, MIN_NEG, 64'd1);
    send_item(OP_NEG, MIN_NEG, 64'd0);
    send_item(OP_ABS, MIN_NEG, '1);
    send_item(OP_MUL, MAX_POS, MAX_POS);
    send_item(OP_QUOT, 64'd7, 64'd0);
    send_item(OP_REM, MIN_NEG, 64'd0);
    send_item(OP_EXDIV, '1, 64'd0);
    send_item(OP_QUOT, MIN_NEG, '1);
    send_item(OP_REM, MIN_NEG, '1);
    send_item(OP_EXDIV, -64'sd7, 64'd2);
    send_item(OP_REM, -64'sd7, 64'd2);
    send_item(OP_EXDIV, 64'd12, -64'sd4);
    send_item(OP_POW, 64'd3, -64'sd1);
    send_item(OP_POW, 64'd0, 64'd0);
    send_item(OP_POW, 64'd3, 64'd40);
    send_item(OP_POW, '1, MAX_POS);
    send_item(OP_SIGN, MIN_NEG, 64'd0);
    send_item(OP_SIGN, 64'd0, 64'd0);
    send_item(OP_SIGN, MAX_POS, 64'd0);
    send_item(OP_EQ, MIN_NEG, MIN_NEG);
    send_item(OP_NE, MIN_NEG, MAX_POS);
    send_item(OP_LT, MIN_NEG, MAX_POS);
    send_item(OP_LE, MAX_POS, MAX_POS);
    send_item(OP_GT, 64'd0, '1);
    send_item(OP_GE, '1, 64'd0);
  endtask

  task automatic test_random_arith(int count);
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: send_item(OP_ADD, rand_operand(), rand_operand());
        1: send_item(OP_SUB, rand_operand(), rand_operand());
        2: send_item(OP_NEG, rand_operand(), rand_operand());
        3: send_item(OP_MUL, rand_operand(), rand_operand());
        4: send_item(OP_ABS, rand_operand(), rand_operand());
        default: send_item(OP_SIGN, rand_operand(), rand_operand());
      endcase
    end
  endtask

  task automatic test_random_divide(int count);
    repeat (count) begin
      case ($urandom_range(0, 2))
        0: send_item(OP_QUOT, rand_operand(), rand_operand());
        1: send_item(OP_REM, rand_operand(), rand_operand());
        default: send_item(OP_EXDIV, rand_operand(), rand_operand());
      endcase
    end
  endtask

  task automatic test_random_compare(int count);
    logic [63:0] a;
    repeat (count) begin
      a = rand_operand();
      // equal operands often, so eq and le see both outcomes
      send_item(opcode_t'($urandom_range(OP_EQ, OP_GE)), a,
                ($urandom_range(0, 3) == 0) ? a : rand_operand());
    end
  endtask

  // exponents mostly small, a few full width, some negative
  task automatic test_random_power(int count);
    logic [63:0] e;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: e = {$urandom, $urandom};
        1: e = 64'(signed'(-$urandom_range(1, 100)));
        default: e = $urandom_range(0, 70);
      endcase
      send_item(OP_POW, rand_operand(), e);
    end
  endtask

  // result receiver with random stalls, compares each transfer
  initial begin : result_check
    alu_result_t exp_res;
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = $urandom_range(0, 7);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && rst_n));
      if (pending_results.size() == 0) begin
        $error("unexpected result value=%h", out_value);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_value !== exp_res.value) begin
          $error("value expected %h actual %h", exp_res.value, out_value);
          fail_count++;
        end
        if (out_error_code !== exp_res.error_code) begin
          $error("error_code expected %0d actual %0d", exp_res.error_code, out_error_code);
          fail_count++;
        end
        if (out_inexact !== exp_res.inexact) begin
          $error("inexact expected %0d actual %0d", exp_res.inexact, out_inexact);
          fail_count++;
        end
      end
    end
  end

  // run limit
  initial begin
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    fail_count = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = 4'd0;
    in_operand_a = 64'd0;
    in_operand_b = 64'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_arith(180);
    test_random_divide(120);
    test_random_compare(140);
    test_random_power(60);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
